// ===== design/fsc_pkg.sv =====
`default_nettype none

package fsc_pkg;

   localparam int XW    = 40;
   localparam int AW    = 48;
   localparam int BW    = 32;
   localparam int PW    = AW + BW;
   localparam int DENW  = 40;
   localparam int NUMW  = 64;
   localparam int QW    = 25;
   localparam int CNTW  = 5;

   localparam longint GLIDE_K    = 328;
   localparam longint THRESH_Q20 = 104858;
   localparam longint ONE_Q20    = 1048576;
   localparam longint IDS_MIN    = 10486;
   localparam longint IDS_K      = 209715;
   localparam longint GR_MIN     = 167772;
   localparam longint GR_ONE     = 16777216;
   localparam longint C_0P1      = 1677722;
   localparam longint C_0P2      = 3355443;
   localparam longint C_0P7      = 11744051;
   localparam longint C_0P9      = 15099494;
   localparam longint C_1P5      = 25165824;
   localparam longint Q23_ONE    = 8388608;
   localparam longint PRE_LIMIT  = 134217728;
   localparam longint ENV_MAX    = 16777215;

   localparam logic [2:0] CSR_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_IN_GAIN  = 3'd1;
   localparam logic [2:0] CSR_OUT_GAIN = 3'd2;
   localparam logic [2:0] CSR_ATTACK   = 3'd3;
   localparam logic [2:0] CSR_RELEASE  = 3'd4;
   localparam logic [2:0] CSR_RATIO    = 3'd5;

   localparam logic [2:0] RATIO_ALL = 3'd4;

   typedef enum logic [4:0] {
      STEP_GIN, STEP_GOUT, STEP_LIN, STEP_RIN, STEP_ENV, STEP_VFAC, STEP_WSQ,
      STEP_GRDIV, STEP_LGR, STEP_RGR, STEP_LOUT, STEP_ROUT, STEP_SC15,
      STEP_SC09, STEP_SC07, STEP_SCLIP, STEP_CSQ, STEP_CCU, STEP_CK
   } step_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_ISSUE, CS_WAIT, CS_WB, CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic signed [23:0] left_in;
      logic signed [23:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] in_gain;
      logic [15:0] out_gain;
      logic [23:0] attack_coef;
      logic [23:0] release_coef;
      logic [2:0]  ratio_select;
   } cfg_type;

   typedef struct packed {
      logic     accept;
      logic     issue;
      logic     skip;
      logic     wb;
      logic     out_load;
      step_type step;
      logic     ch;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic env_above;
      logic out_free;
   } sts_type;

   function automatic logic [23:0] ratio_factor(input logic [2:0] sel);
      case (sel)
         3'd0: ratio_factor = 24'd12582912;
         3'd1: ratio_factor = 24'd14680064;
         3'd2: ratio_factor = 24'd15379115;
         3'd3: ratio_factor = 24'd15938355;
         default: ratio_factor = 24'd16609444;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== design/fsc_ctrl.sv =====
`default_nettype none

module fsc_ctrl import fsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire logic    enable,
   input  wire logic    all_buttons,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;
   step_type       step_ff, step_in, nxt_step;
   logic           ch_ff, ch_in, nxt_ch, last;
   logic           chan_end;

   // step order after a write-back
   always_comb begin
      nxt_step = step_ff;
      nxt_ch   = ch_ff;
      chan_end = 1'b0;
      last     = 1'b0;
      case (step_ff)
         STEP_GIN:   nxt_step = STEP_GOUT;
         STEP_GOUT:  nxt_step = STEP_LIN;
         STEP_LIN:   nxt_step = STEP_RIN;
         STEP_RIN:   nxt_step = STEP_ENV;
         STEP_ENV:   nxt_step = STEP_VFAC;
         STEP_VFAC:  nxt_step = STEP_WSQ;
         STEP_WSQ:   nxt_step = STEP_GRDIV;
         STEP_GRDIV: nxt_step = STEP_LGR;
         STEP_LGR:   nxt_step = STEP_RGR;
         STEP_RGR:   nxt_step = STEP_LOUT;
         STEP_LOUT:  nxt_step = STEP_ROUT;
         STEP_ROUT: begin
            nxt_step = all_buttons ? STEP_SC15 : STEP_CSQ;
            nxt_ch   = 1'b0;
         end
         STEP_SC15:  nxt_step = STEP_SCLIP;
         STEP_SC09:  nxt_step = STEP_SCLIP;
         STEP_SCLIP: begin
            if (all_buttons || ch_ff) nxt_step = STEP_CSQ;
            else chan_end = 1'b1;
         end
         STEP_CSQ:   nxt_step = STEP_CCU;
         STEP_CCU:   nxt_step = STEP_CK;
         STEP_CK: begin
            if (all_buttons) nxt_step = STEP_SC07;
            else if (!ch_ff) nxt_step = STEP_SC09;
            else chan_end = 1'b1;
         end
         STEP_SC07:  chan_end = 1'b1;
         default:    last = 1'b1;
      endcase
      if (chan_end) begin
         if (ch_ff) begin
            last = 1'b1;
         end else begin
            nxt_ch   = 1'b1;
            nxt_step = all_buttons ? STEP_SC15 : STEP_SC09;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ch_in    = ch_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               step_in  = STEP_GIN;
               ch_in    = 1'b0;
               state_in = enable ? CS_ISSUE : CS_DONE;
            end
         end
         CS_ISSUE: begin
            if (step_ff == STEP_VFAC && !sts.env_above) step_in = STEP_LGR;
            else state_in = CS_WAIT;
         end
         CS_WAIT: begin
            if (!sts.busy) state_in = CS_WB;
         end
         CS_WB: begin
            step_in  = nxt_step;
            ch_in    = nxt_ch;
            state_in = last ? CS_DONE : CS_ISSUE;
         end
         CS_DONE: begin
            if (sts.out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = state_ff != CS_IDLE;
      cmd.accept   = state_ff == CS_IDLE && req_valid;
      cmd.skip     = state_ff == CS_ISSUE && step_ff == STEP_VFAC && !sts.env_above;
      cmd.issue    = state_ff == CS_ISSUE && !cmd.skip;
      cmd.wb       = state_ff == CS_WB;
      cmd.out_load = state_ff == CS_DONE && sts.out_free;
      cmd.step     = step_ff;
      cmd.ch       = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= STEP_GIN;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/fsc_datapath.sv =====
`default_nettype none

module fsc_datapath import fsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   input  wire logic    rsp_stall,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic [15:0]             sig_in_ff, sig_in_in, sig_out_ff, sig_out_in;
   logic [23:0]             env_ff, env_in;
   logic signed [XW-1:0]    l_ff, l_in, r_ff, r_in, t_ff, t_in;
   logic [QW-1:0]           gr_ff, gr_in;
   logic signed [AW-1:0]    a_ff, a_in;
   logic signed [BW-1:0]    b_ff, b_in;
   logic signed [PW-1:0]    acc_ff, acc_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, neg_ff, neg_in;
   logic [DENW-1:0]         rem_ff, rem_in, den_ff, den_in;
   logic [QW-1:0]           nlo_ff, nlo_in, q_ff, q_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic signed [XW-1:0]    xcur, al, ar, mx, xnew;
   logic [XW-1:0]           rect_full, mag;
   logic [23:0]             rect;
   logic                    env_gt, is_div;
   logic signed [AW-1:0]    opa;
   logic signed [BW-1:0]    opb;
   logic [4:0]              sh;
   logic [DENW-1:0]         den_set;
   logic [NUMW-1:0]         num_base, num_set;
   logic signed [24:0]      chunk;
   logic signed [56:0]      prod;
   logic [DENW:0]           trial;
   logic signed [PW-1:0]    res;

   function automatic logic signed [PW-1:0] rshr(input logic signed [PW-1:0] p,
                                                 input logic [4:0] s);
      logic signed [PW-1:0] h;
      logic signed [PW-1:0] t;
      h = PW'(1) <<< (s - 5'd1);
      t = p + (p[PW-1] ? h - PW'(1) : h);
      return t >>> s;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [XW-1:0] x);
      if (x > XW'(Q23_ONE - 1)) return 24'sh7FFFFF;
      else if (x < -XW'(Q23_ONE)) return 24'sh800000;
      else return x[23:0];
   endfunction

   assign xcur = cmd.ch ? r_ff : l_ff;
   assign al   = l_ff[XW-1] ? -l_ff : l_ff;
   assign ar   = r_ff[XW-1] ? -r_ff : r_ff;
   assign mx   = (al > ar) ? al : ar;
   assign rect_full = (XW'(mx) + XW'(4)) >> 3;
   assign rect   = (rect_full > XW'(ENV_MAX)) ? 24'hFFFFFF : rect_full[23:0];
   assign env_gt = rect > env_ff;
   assign is_div = cmd.step == STEP_GRDIV || cmd.step == STEP_SCLIP;
   assign mag    = xcur[XW-1] ? XW'(-xcur) : XW'(xcur);

   always_comb begin
      opa = '0;
      opb = '0;
      sh  = 5'd24;
      case (cmd.step)
         STEP_GIN: begin
            opa = AW'($signed({1'b0, cfg.in_gain})) - AW'($signed({1'b0, sig_in_ff}));
            opb = BW'(GLIDE_K);
            sh  = 5'd16;
         end
         STEP_GOUT: begin
            opa = AW'($signed({1'b0, cfg.out_gain})) - AW'($signed({1'b0, sig_out_ff}));
            opb = BW'(GLIDE_K);
            sh  = 5'd16;
         end
         STEP_LIN, STEP_RIN: begin
            opa = AW'(cmd.step == STEP_LIN ? l_ff : r_ff);
            opb = BW'($signed({1'b0, sig_in_ff}));
            sh  = 5'd12;
         end
         STEP_ENV: begin
            opa = AW'($signed({1'b0, rect})) - AW'($signed({1'b0, env_ff}));
            opb = BW'($signed({1'b0, env_gt ? cfg.attack_coef : cfg.release_coef}));
         end
         STEP_VFAC: begin
            opa = AW'($signed({1'b0, env_ff})) - AW'(THRESH_Q20);
            opb = BW'($signed({1'b0, ratio_factor(cfg.ratio_select)}));
         end
         STEP_WSQ: begin
            opa = AW'(t_ff);
            opb = BW'(t_ff);
            sh  = 5'd20;
         end
         STEP_LGR, STEP_RGR: begin
            opa = AW'(cmd.step == STEP_LGR ? l_ff : r_ff);
            opb = BW'($signed({1'b0, gr_ff}));
         end
         STEP_LOUT, STEP_ROUT: begin
            opa = AW'(cmd.step == STEP_LOUT ? l_ff : r_ff);
            opb = BW'($signed({1'b0, sig_out_ff}));
            sh  = 5'd12;
         end
         STEP_SC15: begin
            opa = AW'(xcur);
            opb = BW'(C_1P5);
         end
         STEP_SC09: begin
            opa = AW'(xcur);
            opb = BW'(C_0P9);
         end
         STEP_SC07: begin
            opa = AW'(xcur);
            opb = BW'(C_0P7);
         end
         STEP_CSQ: begin
            opa = AW'(xcur);
            opb = BW'(xcur);
            sh  = 5'd23;
         end
         STEP_CCU: begin
            opa = AW'(t_ff);
            opb = BW'(xcur);
            sh  = 5'd23;
         end
         STEP_CK: begin
            opa = AW'(t_ff);
            opb = (cfg.ratio_select >= RATIO_ALL) ? BW'(C_0P2) : BW'(C_0P1);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // divider set-up: gain reduction or soft clip
   always_comb begin
      if (cmd.step == STEP_GRDIV) begin
         den_set  = DENW'(t_ff) + DENW'(IDS_K);
         num_base = NUMW'(t_ff) << 24;
      end else begin
         den_set  = DENW'(mag) + DENW'(Q23_ONE);
         num_base = NUMW'(mag) << 23;
      end
      num_set = num_base + NUMW'(den_set >> 1);
   end

   assign chunk = (cnt_ff == CNTW'(2)) ? $signed({1'b0, a_ff[23:0]})
                                       : $signed({a_ff[AW-1], a_ff[AW-1:24]});
   assign prod  = chunk * b_ff;
   assign trial = {rem_ff, nlo_ff[QW-1]};
   assign res   = rshr(acc_ff, sh);

   always_comb begin
      sig_in_in    = sig_in_ff;
      sig_out_in   = sig_out_ff;
      env_in       = env_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      gr_in        = gr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      nlo_in       = nlo_ff;
      q_in         = q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      xnew         = xcur;

      if (cmd.accept) begin
         l_in = XW'(req_data.left_in);
         r_in = XW'(req_data.right_in);
      end

      if (cmd.skip) gr_in = QW'(GR_ONE);

      if (cmd.issue) begin
         a_in    = opa;
         b_in    = opb;
         cnt_in  = is_div ? CNTW'(QW) : CNTW'(2);
         busy_in = 1'b1;
         rem_in  = DENW'(num_set >> QW);
         nlo_in  = num_set[QW-1:0];
         den_in  = den_set;
         q_in    = '0;
         neg_in  = xcur[XW-1];
      end else if (busy_ff) begin
         if (is_div) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DENW'(trial - {1'b0, den_ff});
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial[DENW-1:0];
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            nlo_in = {nlo_ff[QW-2:0], 1'b0};
         end else if (cnt_ff == CNTW'(2)) begin
            acc_in = PW'(prod);
         end else begin
            acc_in = acc_ff + (PW'(prod) <<< 24);
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) busy_in = 1'b0;
      end

      if (cmd.wb) begin
         case (cmd.step)
            STEP_GIN:  sig_in_in  = sig_in_ff + res[15:0];
            STEP_GOUT: sig_out_in = sig_out_ff + res[15:0];
            STEP_LIN:  l_in = res[XW-1:0];
            STEP_RIN:  r_in = res[XW-1:0];
            STEP_ENV:  env_in = env_ff + res[23:0];
            STEP_VFAC: t_in = (res > PW'(ONE_Q20)) ? '0 : XW'(ONE_Q20) - res[XW-1:0];
            STEP_WSQ:  t_in = (res < PW'(IDS_MIN)) ? XW'(IDS_MIN) : res[XW-1:0];
            STEP_GRDIV: begin
               if (q_ff < QW'(GR_MIN)) gr_in = QW'(GR_MIN);
               else if (q_ff > QW'(GR_ONE)) gr_in = QW'(GR_ONE);
               else gr_in = q_ff;
            end
            STEP_LGR:  l_in = res[XW-1:0];
            STEP_RGR:  r_in = res[XW-1:0];
            STEP_LOUT, STEP_ROUT: begin
               if (res > PW'(PRE_LIMIT)) xnew = XW'(PRE_LIMIT);
               else if (res < -PW'(PRE_LIMIT)) xnew = -XW'(PRE_LIMIT);
               else xnew = res[XW-1:0];
               if (cmd.step == STEP_LOUT) l_in = xnew;
               else r_in = xnew;
            end
            STEP_CSQ, STEP_CCU: t_in = res[XW-1:0];
            default: begin
               if (cmd.step == STEP_SCLIP) xnew = neg_ff ? -XW'(q_ff) : XW'(q_ff);
               else if (cmd.step == STEP_CK) xnew = xcur + res[XW-1:0];
               else xnew = res[XW-1:0];
               if (cmd.ch) r_in = xnew;
               else l_in = xnew;
            end
         endcase
      end

      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.left_out    = sat24(l_ff);
         rsp_in.right_out   = sat24(r_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_in_ff    <= 16'd4096;
         sig_out_ff   <= 16'd4096;
         env_ff       <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sig_in_ff    <= sig_in_in;
         sig_out_ff   <= sig_out_in;
         env_ff       <= env_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff   <= l_in;
      r_ff   <= r_in;
      t_ff   <= t_in;
      gr_ff  <= gr_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      nlo_ff <= nlo_in;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   assign sts.busy      = busy_ff;
   assign sts.env_above = env_ff > 24'(THRESH_Q20);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

`default_nettype wire

// ===== design/fet_style_stereo_compressor.sv =====
// Stereo compressor with a peak envelope follower and a FET-style gain curve, on Q1.23
// sample pairs. One word is taken at a time. With processing enabled the gain-curve steps
// run only when the envelope is above the threshold, and the all-buttons ratio needs two
// more products. The cost is set by the shared multiplier (two passes of 24 by 32 bits
// per product) and the radix-2 divider used for the gain curve and both soft clips.
// With processing disabled a word passes through. The result waits in an output
// register, so a new word may be taken while the last result is stalled. Registers are
// to be written only while the block is idle; the block itself does not enforce this.
// csr_ready is always high.

`default_nettype none

module fet_style_stereo_compressor import fsc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:   cfg_in.enable       = csr_data[0];
            CSR_IN_GAIN:  cfg_in.in_gain      = csr_data[15:0];
            CSR_OUT_GAIN: cfg_in.out_gain     = csr_data[15:0];
            CSR_ATTACK:   cfg_in.attack_coef  = csr_data;
            CSR_RELEASE:  cfg_in.release_coef = csr_data;
            CSR_RATIO:    cfg_in.ratio_select = csr_data[2:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.in_gain      <= 16'd4096;
         cfg_ff.out_gain     <= 16'd4096;
         cfg_ff.attack_coef  <= 24'd830600;
         cfg_ff.release_coef <= 24'd608;
         cfg_ff.ratio_select <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .enable      (cfg_ff.enable),
      .all_buttons (cfg_ff.ratio_select >= RATIO_ALL),
      .sts         (sts),
      .cmd         (cmd)
   );

   fsc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb_fet_style_stereo_compressor.sv =====
`default_nettype none

module tb_fet_style_stereo_compressor;
   import fsc_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;

   class comp_scoreboard;
      cfg_type cfg;
      longint  env_lvl;
      longint  gin_s;
      longint  gout_s;
      rsp_type pending[$];
      int      errors;

      function new();
         cfg = '{enable: 1'b0, in_gain: 16'd4096, out_gain: 16'd4096,
                 attack_coef: 24'd830600, release_coef: 24'd608, ratio_select: 3'd0};
         env_lvl = 0;
         gin_s   = 4096;
         gout_s  = 4096;
         errors  = 0;
      endfunction

      function longint rnd_shift(longint p, int sh);
         longint m;
         m = (p < 0) ? -p : p;
         m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
         return (p < 0) ? -m : m;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint soft_limit(longint c);
         longint m;
         longint den;
         longint q;
         m = (c < 0) ? -c : c;
         den = Q23_ONE + m;
         q = ((m <<< 23) + den / 2) / den;
         return (c < 0) ? -q : q;
      endfunction

      function longint colour(longint x, longint k);
         longint x3;
         x3 = rnd_shift(rnd_shift(x * x, 23) * x, 23);
         return x + rnd_shift(x3 * k, 24);
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            CSR_ENABLE:   cfg.enable       = val[0];
            CSR_IN_GAIN:  cfg.in_gain      = val[15:0];
            CSR_OUT_GAIN: cfg.out_gain     = val[15:0];
            CSR_ATTACK:   cfg.attack_coef  = val;
            CSR_RELEASE:  cfg.release_coef = val;
            CSR_RATIO:    cfg.ratio_select = val[2:0];
            default: ;
         endcase
      endfunction

      function void note_word(req_type w);
         longint  l, r, al, ar, rect, gr, ol, orr, v, wq, ids, den, fac;
         bit      all_btn;
         rsp_type res;
         l = w.left_in;
         r = w.right_in;
         if (!cfg.enable) begin
            res.left_out  = w.left_in;
            res.right_out = w.right_in;
            pending.push_back(res);
            return;
         end
         gin_s  += rnd_shift((longint'(cfg.in_gain) - gin_s) * GLIDE_K, 16);
         gout_s += rnd_shift((longint'(cfg.out_gain) - gout_s) * GLIDE_K, 16);
         l = rnd_shift(l * gin_s, 12);
         r = rnd_shift(r * gin_s, 12);
         al = l < 0 ? -l : l;
         ar = r < 0 ? -r : r;
         rect = rnd_shift(al > ar ? al : ar, 3);
         if (rect > ENV_MAX) rect = ENV_MAX;
         if (rect > env_lvl)
            env_lvl += rnd_shift((rect - env_lvl) * longint'(cfg.attack_coef), 24);
         else
            env_lvl += rnd_shift((rect - env_lvl) * longint'(cfg.release_coef), 24);
         all_btn = cfg.ratio_select >= RATIO_ALL;
         case (cfg.ratio_select)
            3'd0: fac = 12582912;
            3'd1: fac = 14680064;
            3'd2: fac = 15379115;
            3'd3: fac = 15938355;
            default: fac = 16609444;
         endcase
         gr = GR_ONE;
         if (env_lvl > THRESH_Q20) begin
            v = rnd_shift((env_lvl - THRESH_Q20) * fac, 24);
            if (v > ONE_Q20) v = ONE_Q20;
            wq = ONE_Q20 - v;
            ids = rnd_shift(wq * wq, 20);
            if (ids < IDS_MIN) ids = IDS_MIN;
            den = ids + IDS_K;
            gr = clip(((ids <<< 24) + den / 2) / den, GR_MIN, GR_ONE);
         end
         ol  = clip(rnd_shift(rnd_shift(l * gr, 24) * gout_s, 12), -PRE_LIMIT, PRE_LIMIT);
         orr = clip(rnd_shift(rnd_shift(r * gr, 24) * gout_s, 12), -PRE_LIMIT, PRE_LIMIT);
         if (all_btn) begin
            ol  = soft_limit(rnd_shift(ol * C_1P5, 24));
            orr = soft_limit(rnd_shift(orr * C_1P5, 24));
            ol  = rnd_shift(colour(ol, C_0P2) * C_0P7, 24);
            orr = rnd_shift(colour(orr, C_0P2) * C_0P7, 24);
         end else begin
            ol  = soft_limit(rnd_shift(colour(ol, C_0P1) * C_0P9, 24));
            orr = colour(soft_limit(rnd_shift(orr * C_0P9, 24)), C_0P1);
         end
         res.left_out  = 24'(clip(ol, -Q23_ONE, Q23_ONE - 1));
         res.right_out = 24'(clip(orr, -Q23_ONE, Q23_ONE - 1));
         pending.push_back(res);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected word %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
            errors++;
         end
         if (got.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   comp_scoreboard sb = new();
   bit     calm = 1'b0;
   int     stall_left = 0;
   longint cycles = 0;

   fet_style_stereo_compressor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_fet_style_stereo_compressor NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(req_type w);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   function automatic req_type pair(longint a, longint b);
      req_type w;
      w.left_in  = 24'(a);
      w.right_in = 24'(b);
      return w;
   endfunction

   function automatic req_type rand_word();
      req_type w;
      case ($urandom_range(0, 3))
         0: w = pair($urandom, $urandom);
         1: w = pair(longint'($urandom_range(0, 131072)) - 65536,
                     longint'($urandom_range(0, 131072)) - 65536);
         2: w = pair($urandom_range(0, 1) ? 8388607 - $urandom_range(0, 500000)
                                          : -8388608 + $urandom_range(0, 500000),
                     $urandom);
         default: w = pair(longint'($urandom_range(0, 2000)) - 1000, $urandom);
      endcase
      return w;
   endfunction

   task automatic random_cfg();
      write_csr(CSR_IN_GAIN, $urandom_range(0, 9) == 0 ? 24'($urandom)
                                                       : 24'($urandom_range(0, 12000)));
      write_csr(CSR_OUT_GAIN, $urandom_range(0, 9) == 0 ? 24'($urandom)
                                                        : 24'($urandom_range(0, 12000)));
      write_csr(CSR_ATTACK, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                      : 24'($urandom_range(0, 2000000)));
      write_csr(CSR_RELEASE, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                       : 24'($urandom_range(0, 20000)));
      write_csr(CSR_RATIO, 24'($urandom_range(0, 7)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through while disabled
      send_word(pair(8388607, -8388608));
      send_word(pair(-8388608, 8388607));
      send_word(pair(0, -1));
      drain();

      write_csr(CSR_ENABLE, 24'd1);
      send_word(pair(0, 0));
      send_word(pair(8388607, 8388607));
      send_word(pair(-8388608, -8388608));
      send_word(pair(1, -1));
      for (int s = 0; s < 8; s++) begin
         drain();
         write_csr(CSR_RATIO, 24'(s));
         send_word(pair(8388607, -8388608));
         send_word(pair(4000000, -300000));
      end
      drain();
      // huge gains: pre-colouring saturation and detector clamp
      write_csr(CSR_IN_GAIN, 24'd65535);
      write_csr(CSR_OUT_GAIN, 24'd65535);
      write_csr(CSR_ATTACK, 24'hFFFFFF);
      write_csr(CSR_RELEASE, 24'hFFFFFF);
      write_csr(3'd6, 24'd0);
      write_csr(3'd7, 24'hFFFFFF);
      repeat (4) send_word(pair(8388607, -8388608));
      drain();
      write_csr(CSR_IN_GAIN, 24'd0);
      write_csr(CSR_OUT_GAIN, 24'd0);
      write_csr(CSR_ATTACK, 24'd0);
      write_csr(CSR_RELEASE, 24'd0);
      send_word(pair(8388607, -8388608));
      send_word(pair(-8388608, 8388607));
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         random_cfg();
         if (ph == 4) write_csr(CSR_ENABLE, 24'd0);
         if (ph == 5) write_csr(CSR_ENABLE, 24'd1);
         if (ph == 9) calm = 1'b1;
         for (int i = 0; i < 110; i++) begin
            send_word(rand_word());
            if (ph == 2 && i == 50) begin
               req_valid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_fet_style_stereo_compressor OK");
      end else begin
         $display("tb_fet_style_stereo_compressor NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/fsc_pkg.sv
design/fsc_ctrl.sv
design/fsc_datapath.sv
design/fet_style_stereo_compressor.sv
sim/tb_fet_style_stereo_compressor.sv
